// ----- rtl/nearest_track_association_table_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the track association table
// Immediate-implication and next-cycle property shorthands.
// ----------------------------------------------------------------------------
`ifndef NEAREST_TRACK_ASSOCIATION_TABLE_MACROS_SVH
`define NEAREST_TRACK_ASSOCIATION_TABLE_MACROS_SVH

// same-cycle implication, checked outside reset
`define NTAT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked outside reset
`define NTAT_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/ntat_pkg.sv -----
// ----------------------------------------------------------------------------
// ntat_pkg
// Shared constants, command codes and types of the track association table.
// ----------------------------------------------------------------------------
`default_nettype none

package ntat_pkg;

  localparam int MAX_TRACKS   = 64;
  localparam int IDX_BITS     = $clog2(MAX_TRACKS);
  localparam int CNT_BITS     = $clog2(MAX_TRACKS + 1);
  localparam int COORD_BITS   = 12;
  localparam int FRAME_BITS   = 32;
  localparam int AGE_BITS     = 32;
  localparam int DIST_BITS    = 13;
  localparam int IDLE_BITS    = 16;
  localparam int DSQ_BITS     = 2 * DIST_BITS;
  localparam int CFG_IDX_BITS = 1;
  localparam int CFG_DAT_BITS = 16;

  localparam logic [DIST_BITS-1:0] MAX_DIST_RST = DIST_BITS'(50);
  localparam logic [IDLE_BITS-1:0] MAX_IDLE_RST = IDLE_BITS'(20);

  typedef enum logic [2:0] {
    CMD_FRAME = 3'd0,
    CMD_MATCH = 3'd1,
    CMD_ADD   = 3'd2,
    CMD_PURGE = 3'd3,
    CMD_READ  = 3'd4,
    CMD_CLEAR = 3'd5
  } cmd_t;

  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_FULL  = 2'd1;
  localparam logic [1:0] STAT_RANGE = 2'd2;

  localparam logic [CFG_IDX_BITS-1:0] CFG_MAX_DIST = 1'b0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_MAX_IDLE = 1'b1;

  typedef struct packed {
    logic [FRAME_BITS-1:0] stamp;
    logic [COORD_BITS-1:0] y;
    logic [COORD_BITS-1:0] x;
  } track_entry_t;

  typedef struct packed {
    logic                 en;
    logic [IDX_BITS-1:0]  addr;
    track_entry_t         data;
  } mem_wr_t;

  typedef struct packed {
    logic                 en;
    logic [IDX_BITS-1:0]  addr;
  } mem_rd_t;

  typedef struct packed {
    logic load;   // acc = op^2
    logic accum;  // acc = acc + op^2
  } dist_ctl_t;

endpackage

`default_nettype wire

// ----- rtl/ntat_track_mem.sv -----
// ----------------------------------------------------------------------------
// ntat_track_mem
// Track table storage: one write port, one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module ntat_track_mem (
  input  wire logic                 clk,
  input  wire ntat_pkg::mem_wr_t    wr_i,
  input  wire ntat_pkg::mem_rd_t    rd_i,
  output ntat_pkg::track_entry_t    rd_data_o
);

  ntat_pkg::track_entry_t mem_r [ntat_pkg::MAX_TRACKS];
  ntat_pkg::track_entry_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_i.en) begin
      mem_r[wr_i.addr] <= wr_i.data;
    end
    if (rd_i.en) begin
      rd_data_r <= mem_r[rd_i.addr];
    end
  end

  assign rd_data_o = rd_data_r;

endmodule

`default_nettype wire

// ----- rtl/ntat_dist_unit.sv -----
// ----------------------------------------------------------------------------
// ntat_dist_unit
// Shared square-and-accumulate unit for squared distances and the limit.
// ----------------------------------------------------------------------------
`default_nettype none

module ntat_dist_unit (
  input  wire logic                           clk,
  input  wire ntat_pkg::dist_ctl_t            ctl_i,
  input  wire logic [ntat_pkg::DIST_BITS-1:0] op_i,
  output logic      [ntat_pkg::DSQ_BITS-1:0]  acc_o
);

  logic [ntat_pkg::DSQ_BITS-1:0] acc_r;
  logic [ntat_pkg::DSQ_BITS-1:0] sq;

  assign sq = ntat_pkg::DSQ_BITS'(op_i) * ntat_pkg::DSQ_BITS'(op_i);

  always_ff @(posedge clk) begin
    if (ctl_i.load) begin
      acc_r <= sq;
    end else if (ctl_i.accum) begin
      acc_r <= acc_r + sq;
    end
  end

  assign acc_o = acc_r;

endmodule

`default_nettype wire

// ----- rtl/nearest_track_association_table.sv -----
// ----------------------------------------------------------------------------
// nearest_track_association_table
// Ordered track table: frame step, nearest-point match, append, purge, read, clear.
// ----------------------------------------------------------------------------
//  channel | dir | handshake          | payload
//  in_     | in  | in_tvalid/tready   | tuser: cmd; tdata: pos_x, pos_y, entry_index
//  out_    | out | out_tvalid/tready  | tdata: found, prev_x, prev_y, track_count,
//          |     |                    |        max_age, status
//  cfg_    | in  | cfg_valid/ready    | cfg_index, cfg_data
//
// One command at a time; in_tready is high only while the sequencer idles.
// Match and purge walk the stored tracks one by one through the single read
// port; match also squares each distance in the shared squaring unit.
// Results sit in an output register; a stalled out_ channel holds the
// sequencer in its final state.
// Reset (rst_n low, synchronous) empties the table, zeroes frame and max age.
// ----------------------------------------------------------------------------
`default_nettype none
`include "nearest_track_association_table_macros.svh"

module nearest_track_association_table (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [31:0] in_tdata,   // [11:0] pos_x, [23:12] pos_y, [29:24] entry_index
  input  wire logic [2:0]  in_tuser,   // [2:0] cmd
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [71:0]      out_tdata,  // [0] found, [12:1] prev_x, [24:13] prev_y,
                                       // [31:25] track_count, [63:32] max_age,
                                       // [65:64] status
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [ntat_pkg::CFG_IDX_BITS-1:0] cfg_index,
  input  wire logic [ntat_pkg::CFG_DAT_BITS-1:0] cfg_data
);

  localparam int CB = ntat_pkg::COORD_BITS;
  localparam int NB = ntat_pkg::CNT_BITS;
  localparam int IB = ntat_pkg::IDX_BITS;
  localparam int FB = ntat_pkg::FRAME_BITS;
  localparam int DB = ntat_pkg::DSQ_BITS;

  typedef enum logic [3:0] {
    S_IDLE, S_EXEC, S_LIMIT, S_M_READ, S_M_DX, S_M_DY, S_M_CMP, S_M_UPD,
    S_P_READ, S_P_EVAL, S_R_DATA, S_OUT
  } state_t;

  function automatic logic [CB-1:0] abs_diff(input logic [CB-1:0] a, input logic [CB-1:0] b);
    abs_diff = (a > b) ? (a - b) : (b - a);
  endfunction

  state_t                 state_r, state_nxt;
  ntat_pkg::cmd_t         cmd_r, cmd_nxt;
  logic [CB-1:0]          px_r, px_nxt, py_r, py_nxt;
  logic [IB-1:0]          idx_r, idx_nxt;
  logic [NB-1:0]          used_r, used_nxt;
  logic [FB-1:0]          frame_r, frame_nxt;
  logic [ntat_pkg::AGE_BITS-1:0] largest_r, largest_nxt;
  logic [ntat_pkg::DIST_BITS-1:0] max_dist_r, max_dist_nxt;
  logic [ntat_pkg::IDLE_BITS-1:0] max_idle_r, max_idle_nxt;
  logic [NB-1:0]          scan_r, scan_nxt, wr_r, wr_nxt;
  logic                   have_r, have_nxt;
  logic [DB-1:0]          best_r, best_nxt, limit_r, limit_nxt;
  logic [IB-1:0]          sel_r, sel_nxt;
  ntat_pkg::track_entry_t best_ent_r, best_ent_nxt, ent_r, ent_nxt;
  logic                   found_r, found_nxt;
  logic [CB-1:0]          ox_r, ox_nxt, oy_r, oy_nxt;
  logic [1:0]             status_r, status_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic [71:0]            out_data_r, out_data_nxt;

  ntat_pkg::mem_wr_t      mem_wr;
  ntat_pkg::mem_rd_t      mem_rd;
  ntat_pkg::track_entry_t rd_data;
  ntat_pkg::dist_ctl_t    dist_ctl;
  logic [ntat_pkg::DIST_BITS-1:0] dist_op;
  logic [DB-1:0]          dist_acc;
  logic [FB-1:0]          age;
  logic                   drop;

  ntat_track_mem u_mem (
    .clk       (clk),
    .wr_i      (mem_wr),
    .rd_i      (mem_rd),
    .rd_data_o (rd_data)
  );

  ntat_dist_unit u_dist (
    .clk   (clk),
    .ctl_i (dist_ctl),
    .op_i  (dist_op),
    .acc_o (dist_acc)
  );

  assign in_tready  = (state_r == S_IDLE);
  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  assign age  = frame_r - best_ent_r.stamp;
  assign drop = (rd_data.stamp <= frame_r) &&
                ((frame_r - rd_data.stamp) >= FB'(max_idle_r));

  always_comb begin
    state_nxt     = state_r;
    cmd_nxt       = cmd_r;
    px_nxt        = px_r;
    py_nxt        = py_r;
    idx_nxt       = idx_r;
    used_nxt      = used_r;
    frame_nxt     = frame_r;
    largest_nxt   = largest_r;
    max_dist_nxt  = max_dist_r;
    max_idle_nxt  = max_idle_r;
    scan_nxt      = scan_r;
    wr_nxt        = wr_r;
    have_nxt      = have_r;
    best_nxt      = best_r;
    limit_nxt     = limit_r;
    sel_nxt       = sel_r;
    best_ent_nxt  = best_ent_r;
    ent_nxt       = ent_r;
    found_nxt     = found_r;
    ox_nxt        = ox_r;
    oy_nxt        = oy_r;
    status_nxt    = status_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    mem_wr        = '0;
    mem_rd        = '0;
    dist_ctl      = '0;
    dist_op       = '0;

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    if (cfg_valid) begin
      case (cfg_index)
        ntat_pkg::CFG_MAX_DIST: max_dist_nxt = cfg_data[ntat_pkg::DIST_BITS-1:0];
        ntat_pkg::CFG_MAX_IDLE: max_idle_nxt = cfg_data[ntat_pkg::IDLE_BITS-1:0];
        default: ;
      endcase
    end

    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd_nxt    = ntat_pkg::cmd_t'(in_tuser);
          px_nxt     = in_tdata[11:0];
          py_nxt     = in_tdata[23:12];
          idx_nxt    = in_tdata[29:24];
          found_nxt  = 1'b0;
          ox_nxt     = '0;
          oy_nxt     = '0;
          status_nxt = ntat_pkg::STAT_OK;
          scan_nxt   = '0;
          wr_nxt     = '0;
          have_nxt   = 1'b0;
          state_nxt  = S_EXEC;
        end
      end

      S_EXEC: begin
        state_nxt = S_OUT;
        case (cmd_r)
          ntat_pkg::CMD_FRAME: frame_nxt = frame_r + FB'(1);
          ntat_pkg::CMD_MATCH: state_nxt = S_LIMIT;
          ntat_pkg::CMD_ADD: begin
            if (used_r >= NB'(ntat_pkg::MAX_TRACKS)) begin
              status_nxt = ntat_pkg::STAT_FULL;
            end else begin
              mem_wr.en   = 1'b1;
              mem_wr.addr = used_r[IB-1:0];
              mem_wr.data = '{stamp: frame_r, y: py_r, x: px_r};
              used_nxt    = used_r + NB'(1);
            end
          end
          ntat_pkg::CMD_PURGE: state_nxt = S_P_READ;
          ntat_pkg::CMD_READ: begin
            if ({1'b0, idx_r} >= used_r) begin
              status_nxt = ntat_pkg::STAT_RANGE;
            end else begin
              mem_rd.en   = 1'b1;
              mem_rd.addr = idx_r;
              state_nxt   = S_R_DATA;
            end
          end
          ntat_pkg::CMD_CLEAR: begin
            used_nxt    = '0;
            frame_nxt   = '0;
            largest_nxt = '0;
          end
          default: ;
        endcase
      end

      S_LIMIT: begin
        dist_ctl.load = 1'b1;
        dist_op       = max_dist_r;
        state_nxt     = S_M_READ;
      end

      S_M_READ: begin
        // the unit still holds max_distance^2 before the first entry
        if (scan_r == '0) begin
          limit_nxt = dist_acc;
        end
        if (scan_r >= used_r) begin
          state_nxt = S_M_UPD;
        end else begin
          mem_rd.en   = 1'b1;
          mem_rd.addr = scan_r[IB-1:0];
          state_nxt   = S_M_DX;
        end
      end

      S_M_DX: begin
        ent_nxt       = rd_data;
        dist_ctl.load = 1'b1;
        dist_op       = {1'b0, abs_diff(rd_data.x, px_r)};
        state_nxt     = S_M_DY;
      end

      S_M_DY: begin
        dist_ctl.accum = 1'b1;
        dist_op        = {1'b0, abs_diff(ent_r.y, py_r)};
        state_nxt      = S_M_CMP;
      end

      S_M_CMP: begin
        // stamps ahead of the frame (after a wrap) never match
        if ((ent_r.stamp <= frame_r) && (dist_acc <= limit_r) &&
            (!have_r || (dist_acc < best_r))) begin
          have_nxt     = 1'b1;
          best_nxt     = dist_acc;
          sel_nxt      = scan_r[IB-1:0];
          best_ent_nxt = ent_r;
        end
        scan_nxt  = scan_r + NB'(1);
        state_nxt = S_M_READ;
      end

      S_M_UPD: begin
        if (have_r) begin
          found_nxt   = 1'b1;
          ox_nxt      = best_ent_r.x;
          oy_nxt      = best_ent_r.y;
          mem_wr.en   = 1'b1;
          mem_wr.addr = sel_r;
          mem_wr.data = '{stamp: frame_r, y: py_r, x: px_r};
          if (age > largest_r) begin
            largest_nxt = age;
          end
        end
        state_nxt = S_OUT;
      end

      S_P_READ: begin
        if (scan_r >= used_r) begin
          used_nxt  = wr_r;
          state_nxt = S_OUT;
        end else begin
          mem_rd.en   = 1'b1;
          mem_rd.addr = scan_r[IB-1:0];
          state_nxt   = S_P_EVAL;
        end
      end

      S_P_EVAL: begin
        // compaction: write slot never runs ahead of the read slot
        if (!drop) begin
          mem_wr.en   = 1'b1;
          mem_wr.addr = wr_r[IB-1:0];
          mem_wr.data = rd_data;
          wr_nxt      = wr_r + NB'(1);
        end
        scan_nxt  = scan_r + NB'(1);
        state_nxt = S_P_READ;
      end

      S_R_DATA: begin
        ox_nxt    = rd_data.x;
        oy_nxt    = rd_data.y;
        state_nxt = S_OUT;
      end

      S_OUT: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {6'b0, status_r, largest_r, used_r, oy_r, ox_r, found_r};
          state_nxt     = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      used_r      <= '0;
      frame_r     <= '0;
      largest_r   <= '0;
      max_dist_r  <= ntat_pkg::MAX_DIST_RST;
      max_idle_r  <= ntat_pkg::MAX_IDLE_RST;
      scan_r      <= '0;
      wr_r        <= '0;
      have_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      used_r      <= used_nxt;
      frame_r     <= frame_nxt;
      largest_r   <= largest_nxt;
      max_dist_r  <= max_dist_nxt;
      max_idle_r  <= max_idle_nxt;
      scan_r      <= scan_nxt;
      wr_r        <= wr_nxt;
      have_r      <= have_nxt;
      out_valid_r <= out_valid_nxt;
    end
    cmd_r      <= cmd_nxt;
    px_r       <= px_nxt;
    py_r       <= py_nxt;
    idx_r      <= idx_nxt;
    best_r     <= best_nxt;
    limit_r    <= limit_nxt;
    sel_r      <= sel_nxt;
    best_ent_r <= best_ent_nxt;
    ent_r      <= ent_nxt;
    found_r    <= found_nxt;
    ox_r       <= ox_nxt;
    oy_r       <= oy_nxt;
    status_r   <= status_nxt;
    out_data_r <= out_data_nxt;
  end

  `NTAT_ASSERT_NOW(a_count_bound, 1'b1, used_r <= NB'(ntat_pkg::MAX_TRACKS), "track count above table size")
  `NTAT_ASSERT_NOW(a_compact_order, (state_r == S_P_EVAL) || (state_r == S_P_READ), wr_r <= scan_r, "purge write slot passed read slot")
  `NTAT_ASSERT_NOW(a_scan_in_table, state_r == S_M_CMP, scan_r < used_r, "match compared entry past table end")
  `NTAT_ASSERT_NXT(a_busy_after_beat, in_tvalid && in_tready, !in_tready, "input taken while command in work")

endmodule

`default_nettype wire
